// File: rtl/core/lmsfir_pkg.sv
// ----------------------------------------------------------------------------
// LMS FIR identifier package
// Shared sizes, formats, controller states and the weight step function.
// ----------------------------------------------------------------------------
package lmsfir_pkg;

	localparam int TAPS   = 160;
	localparam int ADDR_W = $clog2(TAPS);
	localparam int CNT_W  = $clog2(TAPS + 1);
	localparam int SMP_W  = 16;
	localparam int COEF_W = 16;
	localparam int IDX_W  = 8;
	localparam int W_W    = 48;
	localparam int MU_W   = 6;
	localparam int FRAC   = 30;
	localparam int CPROD_W = SMP_W + COEF_W;
	localparam int DES_W  = CPROD_W + $clog2(TAPS);
	localparam int ACC_W  = 64;
	localparam int ERR_W  = 34;
	localparam int UPROD_W = ERR_W + SMP_W;
	localparam int INC_W  = 50;
	localparam int SH_W   = 96;

	localparam logic [MU_W-1:0] MU_RESET = MU_W'(36);
	localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIR,
		ST_ERR,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_COEF   = 1'b1
	} req_t;

	// Weight increment: product scaled by 2^(30-mu), clipped to +-2^48 when
	// scaled up, arithmetic right shift when scaled down.
	function automatic logic signed [INC_W-1:0] weight_step(
		input logic signed [UPROD_W-1:0] p,
		input logic [MU_W-1:0] mu
	);
		logic signed [SH_W-1:0] sh;
		logic signed [SH_W-1:0] lim;
		logic signed [INC_W-1:0] r;
		lim = SH_W'(1) <<< W_W;
		sh = SH_W'(p);
		if (mu >= MU_W'(FRAC)) begin
			r = INC_W'(p >>> (mu - MU_W'(FRAC)));
		end else begin
			sh = sh <<< (MU_W'(FRAC) - mu);
			if (sh > lim) begin
				r = INC_W'(lim);
			end else if (sh < -lim) begin
				r = INC_W'(-lim);
			end else begin
				r = sh[INC_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/lmsfir_if.sv
// ----------------------------------------------------------------------------
// LMS FIR identifier channels
// Valid/ready channels for requests and error results.
// ----------------------------------------------------------------------------
interface lmsfir_in_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic signed [lmsfir_pkg::SMP_W-1:0]  sample_value;
	logic        [lmsfir_pkg::IDX_W-1:0]  coef_index;
	logic signed [lmsfir_pkg::COEF_W-1:0] coef_value;

	modport source (output valid, req_type, sample_value, coef_index, coef_value,
		input ready);
	modport sink (input valid, req_type, sample_value, coef_index, coef_value,
		output ready);
endinterface

interface lmsfir_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lmsfir_pkg::SMP_W-1:0] error_value;
	logic                                saturated;

	modport source (output valid, error_value, saturated, input ready);
	modport sink (input valid, error_value, saturated, output ready);
endinterface

// File: rtl/core/lms_adaptive_fir_identifier_top.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR system identifier
// Reference FIR, adaptive FIR and LMS weight update around three memories.
// ----------------------------------------------------------------------------
// A sample transfer on smp starts one identification step: the sample enters
// a 160-entry tap line, a reference FIR (coefficients loaded earlier by
// coefficient transfers) gives the desired value, the adaptive FIR gives the
// estimate, and the error drives the LMS update of all 160 weights. One error
// result per sample leaves on res; coefficient transfers give no result. A
// sample takes one pass of 160 memory reads for both dot products, then one
// pass of 160 read-modify-writes over the weight memory, each pass draining
// its pipeline; each memory is read through a single read port.
// After reset the block zeroes the tap and weight memories and takes no
// request meanwhile. The mu_shift register (write cfg_we with cfg_wdata) may
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_identifier_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lmsfir_pkg::MU_W-1:0]  cfg_wdata,
	lmsfir_in_if.sink                    smp,
	lmsfir_out_if.source                 res
);
	import lmsfir_pkg::*;

	// Memories: tap line is a circular buffer indexed from head_q.
	logic signed [SMP_W-1:0]  tap_mem  [TAPS];
	logic signed [W_W-1:0]    w_mem    [TAPS];
	logic signed [COEF_W-1:0] coef_mem [TAPS];

	state_t state_q, state_d;
	logic [MU_W-1:0]   mu_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] head_dec;
	logic [CNT_W-1:0]  cnt_q;
	logic              issue;
	logic [ADDR_W:0]   tap_sum;
	logic [ADDR_W-1:0] tap_addr;
	logic              smp_xfer;

	// Pipeline: s1 = memory read data, s2 = products, s3 = weight increment
	logic                     rd_v_s1, mul_v_s2, upd_v_s3;
	logic [ADDR_W-1:0]        addr_s1, addr_s2, addr_s3;
	logic signed [SMP_W-1:0]  tap_s1;
	logic signed [W_W-1:0]    w_s1, w_s2, w_s3;
	logic signed [COEF_W-1:0] coef_s1;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [CPROD_W-1:0] cprod_s2;
	logic signed [INC_W-1:0]  inc_s3;
	logic signed [W_W-1:0]    mult_a;

	logic signed [DES_W-1:0] des_q;
	logic signed [ACC_W-1:0] est_q;
	logic signed [ERR_W-1:0] err_q;

	logic signed [ACC_W:0]   est_sum;
	logic signed [ACC_W-1:0] est_next;
	logic signed [ACC_W+1:0] diff_w;
	logic signed [ACC_W-1:0] diff;
	logic [ACC_W-1:0]        diff_mag;
	logic [ERR_W-1:0]        err_mag;
	logic signed [ERR_W-1:0] err_d;
	logic signed [INC_W:0]   w_sum;
	logic signed [W_W-1:0]   w_new;
	logic                    pipe_busy;

	logic                    res_valid_q;
	logic signed [SMP_W-1:0] res_err_q;
	logic                    res_sat_q;

	assign smp.ready = (state_q == ST_IDLE);
	assign smp_xfer  = smp.valid && smp.ready;
	assign res.valid = res_valid_q;
	assign res.error_value = res_err_q;
	assign res.saturated   = res_sat_q;

	// New sample goes one place below the current head; the oldest tap drops.
	assign head_dec = (head_q == '0) ? ADDR_W'(TAPS - 1) : head_q - 1'b1;
	assign tap_sum  = {1'b0, head_q} + {1'b0, cnt_q[ADDR_W-1:0]};
	assign tap_addr = (tap_sum >= (ADDR_W+1)'(TAPS)) ?
		ADDR_W'(tap_sum - (ADDR_W+1)'(TAPS)) : tap_sum[ADDR_W-1:0];

	assign issue = (state_q == ST_FIR || state_q == ST_UPD) && (cnt_q < CNT_W'(TAPS));
	assign pipe_busy = rd_v_s1 || mul_v_s2 || upd_v_s3;

	// Shared multiplier: weight*tap for the estimate, error*tap for the update
	assign mult_a = (state_q == ST_FIR) ? w_s1 : W_W'(err_q);

	// Saturating estimate accumulation to +-(2^63-1)
	always_comb begin
		est_sum = (ACC_W+1)'(est_q) + (ACC_W+1)'(prod_s2);
		if (est_sum > (ACC_W+1)'(ACC_MAX)) begin
			est_next = ACC_MAX;
		end else if (est_sum < -(ACC_W+1)'(ACC_MAX)) begin
			est_next = -ACC_MAX;
		end else begin
			est_next = est_sum[ACC_W-1:0];
		end
	end

	// Error: ((desired << 15) - estimate) >> 30, saturated, truncated toward zero
	always_comb begin
		diff_w = ((ACC_W+2)'(des_q) <<< 15) - (ACC_W+2)'(est_q);
		if (diff_w > (ACC_W+2)'(ACC_MAX)) begin
			diff = ACC_MAX;
		end else if (diff_w < -(ACC_W+2)'(ACC_MAX)) begin
			diff = -ACC_MAX;
		end else begin
			diff = diff_w[ACC_W-1:0];
		end
		diff_mag = diff[ACC_W-1] ? ACC_W'(-diff) : ACC_W'(diff);
		err_mag  = ERR_W'(diff_mag >> FRAC);
		err_d    = diff[ACC_W-1] ? -$signed(err_mag) : $signed(err_mag);
	end

	// Weight write-back, saturated to 48 bits
	always_comb begin
		w_sum = (INC_W+1)'(w_s3) + (INC_W+1)'(inc_s3);
		if (w_sum > $signed((INC_W+1)'({1'b0, {(W_W-1){1'b1}}}))) begin
			w_new = {1'b0, {(W_W-1){1'b1}}};
		end else if (w_sum < -$signed((INC_W+1)'({1'b0, {(W_W-1){1'b1}}})) - 1) begin
			w_new = {1'b1, {(W_W-1){1'b0}}};
		end else begin
			w_new = w_sum[W_W-1:0];
		end
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			tap_mem[cnt_q[ADDR_W-1:0]] <= '0;
		end else if (smp_xfer && smp.req_type == REQ_SAMPLE) begin
			tap_mem[head_dec] <= smp.sample_value;
		end
		if (state_q == ST_CLEAR) begin
			w_mem[cnt_q[ADDR_W-1:0]] <= '0;
		end else if (upd_v_s3) begin
			w_mem[addr_s3] <= w_new;
		end
		if (smp_xfer && smp.req_type == REQ_COEF && smp.coef_index < IDX_W'(TAPS)) begin
			coef_mem[smp.coef_index[ADDR_W-1:0]] <= smp.coef_value;
		end
		tap_s1  <= tap_mem[tap_addr];
		w_s1    <= w_mem[cnt_q[ADDR_W-1:0]];
		coef_s1 <= coef_mem[cnt_q[ADDR_W-1:0]];
	end

	// Datapath pipeline payload
	always_ff @(posedge clk) begin
		addr_s1  <= cnt_q[ADDR_W-1:0];
		addr_s2  <= addr_s1;
		addr_s3  <= addr_s2;
		w_s2     <= w_s1;
		w_s3     <= w_s2;
		prod_s2  <= ACC_W'(mult_a) * ACC_W'(tap_s1);
		cprod_s2 <= CPROD_W'(coef_s1) * CPROD_W'(tap_s1);
		inc_s3   <= weight_step(prod_s2[UPROD_W-1:0], mu_q);
	end

	// Controller, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mu_q        <= MU_RESET;
			head_q      <= '0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			upd_v_s3    <= 1'b0;
			des_q       <= '0;
			est_q       <= '0;
			err_q       <= '0;
			res_valid_q <= 1'b0;
			res_err_q   <= '0;
			res_sat_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= issue;
			mul_v_s2 <= rd_v_s1;
			upd_v_s3 <= mul_v_s2 && (state_q == ST_UPD);
			if (cfg_we) begin
				mu_q <= cfg_wdata;
			end
			// advance the sweep counter; restart it at every pass boundary
			if (state_q == ST_CLEAR) begin
				cnt_q <= (cnt_q == CNT_W'(TAPS - 1)) ? '0 : cnt_q + 1'b1;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_IDLE || state_q == ST_ERR) begin
				cnt_q <= '0;
			end
			if (smp_xfer && smp.req_type == REQ_SAMPLE) begin
				head_q <= head_dec;
				des_q  <= '0;
				est_q  <= '0;
			end
			if (mul_v_s2 && state_q == ST_FIR) begin
				des_q <= des_q + DES_W'(cprod_s2);
				est_q <= est_next;
			end
			if (state_q == ST_ERR) begin
				err_q <= err_d;
			end
			// hold the result until taken; load the new one when free
			if (state_q == ST_OUT && (!res_valid_q || res.ready)) begin
				res_valid_q <= 1'b1;
				if (err_q > ERR_W'(32767)) begin
					res_err_q <= 16'sh7FFF;
					res_sat_q <= 1'b1;
				end else if (err_q < -ERR_W'(32768)) begin
					res_err_q <= 16'sh8000;
					res_sat_q <= 1'b1;
				end else begin
					res_err_q <= err_q[SMP_W-1:0];
					res_sat_q <= 1'b0;
				end
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_q == CNT_W'(TAPS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (smp_xfer && smp.req_type == REQ_SAMPLE) begin
					state_d = ST_FIR;
				end
			end
			ST_FIR: begin
				if (cnt_q == CNT_W'(TAPS) && !pipe_busy) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR: state_d = ST_UPD;
			ST_UPD: begin
				if (cnt_q == CNT_W'(TAPS) && !pipe_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pipe_busy)
		else $error("pipeline active while idle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TAPS))
		else $error("sweep counter past tap count");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < ADDR_W'(TAPS))
		else $error("tap head out of range");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && state_d == ST_IDLE) |=> res_valid_q)
		else $error("result not presented after update pass");

	a_wb_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		upd_v_s3 |-> (state_q == ST_UPD))
		else $error("weight write-back outside update pass");

endmodule
